// File: src/fastq_record_parser_trim_top_defines.svh
// Assertion macros used by the FASTQ parser RTL.
`ifndef FASTQ_RECORD_PARSER_TRIM_TOP_DEFINES_SVH
`define FASTQ_RECORD_PARSER_TRIM_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FQP_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FQP_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/fqp_pkg.sv
// Package with types, codes and constants of the FASTQ record parser.
package fqp_pkg;

    localparam int MAX_READ_DEF = 1024;
    localparam int MAX_NAME_DEF = 64;

    localparam int KEEP_W     = 17;
    localparam int CUTOFF_W   = 11;
    localparam int SEP_LEN_W  = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    // Unity keep fraction: bit 16 set means no scaling.
    localparam logic [KEEP_W-1:0]    KEEP_RESET   = 17'h10000;
    localparam logic [CUTOFF_W-1:0]  CUTOFF_RESET = 11'd1024;
    localparam logic [SEP_LEN_W-1:0] SEP_LEN_MAX  = 11'd2047;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_PLUS    = 8'h2B;

    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_FRACTION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_CUTOFF   = 1'b1;

    typedef enum logic [1:0] {
        PH_NAME,
        PH_SEQ,
        PH_SEP,
        PH_QUAL
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NAME = 2'd0,
        KIND_PAIR = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_NAME     = 3'd1,
        ST_BAD_SEP      = 3'd2,
        ST_LEN_MISMATCH = 3'd3,
        ST_TRUNCATED    = 3'd4,
        ST_OVERFLOW     = 3'd5
    } status_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [7:0] qual_byte;
        status_t    status;
    } result_t;

    typedef struct packed {
        logic       name_push;
        logic       sep_push;
        logic [7:0] data;
    } match_ctl_t;

endpackage

// File: src/fqp_channels.sv
// Valid/ready channel interfaces for the parser input and output words.
interface fqp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       stream_end;

    modport source (output valid, output ch, output stream_end, input ready);
    modport sink (input valid, input ch, input stream_end, output ready);
endinterface

interface fqp_out_if;
    logic            valid;
    logic            ready;
    fqp_pkg::kind_t   kind;
    logic [7:0]      data_byte;
    logic [7:0]      qual_byte;
    fqp_pkg::status_t status;

    modport source (output valid, output kind, output data_byte, output qual_byte,
                    output status, input ready);
    modport sink (input valid, input kind, input data_byte, input qual_byte,
                  input status, output ready);
endinterface

// File: src/fqp_sep_match.sv
// Separator-versus-name suffix match: reversed name line, separator tail, per-byte compare.
module fqp_sep_match #(
    parameter int MAX_NAME = fqp_pkg::MAX_NAME_DEF,
    parameter int NLEN_W   = $clog2(fqp_pkg::MAX_NAME_DEF + 1)
) (
    input  logic                           clk,
    input  fqp_pkg::match_ctl_t            ctl,
    input  logic [NLEN_W-1:0]              name_len,
    input  logic [fqp_pkg::SEP_LEN_W-1:0]  sep_len,
    output logic                           match
);
    import fqp_pkg::*;

    // Newest byte sits at index 0 in both lines, so tap k of each lines up.
    logic [7:0]          name_rev_reg [MAX_NAME];
    logic [7:0]          name_rev_next [MAX_NAME];
    logic [7:0]          tail_reg [MAX_NAME];
    logic [7:0]          tail_next [MAX_NAME];
    logic [MAX_NAME-1:0] eq_reg;
    logic [MAX_NAME-1:0] eq_next;
    logic [MAX_NAME-1:0] hit;

    always_comb
    begin
        for (int k = 0; k < MAX_NAME; k++)
        begin
            if (k == 0)
            begin
                name_rev_next[k] = ctl.name_push ? ctl.data : name_rev_reg[k];
                tail_next[k]     = ctl.sep_push ? ctl.data : tail_reg[k];
            end
            else
            begin
                name_rev_next[k] = ctl.name_push ? name_rev_reg[k-1] : name_rev_reg[k];
                tail_next[k]     = ctl.sep_push ? tail_reg[k-1] : tail_reg[k];
            end
            eq_next[k] = (name_rev_next[k] == tail_next[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.name_push || ctl.sep_push)
        begin
            name_rev_reg <= name_rev_next;
            tail_reg     <= tail_next;
            eq_reg       <= eq_next;
        end
    end

    // Taps past the name length do not count.
    always_comb
    begin
        for (int k = 0; k < MAX_NAME; k++)
        begin
            hit[k] = eq_reg[k] || (32'(k) >= 32'(name_len));
        end
    end

    assign match = (sep_len == SEP_LEN_W'(1))
                || ((32'(sep_len) >= 32'(name_len)) && (&hit));

endmodule

// File: src/fqp_out_skid.sv
// Two-entry output stage: result register plus skid register.
module fqp_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fqp_pkg::result_t  item,
    output logic              ready,
    fqp_out_if.source         tx
);
    import fqp_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_reg;
    result_t skid_reg;
    logic    out_load;
    logic    skid_load;

    always_comb
    begin
        out_load        = 1'b0;
        skid_load       = 1'b0;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        priority if (skid_valid_reg)
        begin
            out_load        = tx.ready;
            skid_valid_next = !tx.ready;
            out_valid_next  = 1'b1;
        end
        else if (push)
        begin
            out_load        = !out_valid_reg || tx.ready;
            skid_load       = out_valid_reg && !tx.ready;
            skid_valid_next = skid_load;
            out_valid_next  = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !tx.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= skid_valid_reg ? skid_reg : item;
        end
        if (skid_load)
        begin
            skid_reg <= item;
        end
    end

    assign ready        = !skid_valid_reg;
    assign tx.valid     = out_valid_reg;
    assign tx.kind      = out_reg.kind;
    assign tx.data_byte = out_reg.data_byte;
    assign tx.qual_byte = out_reg.qual_byte;
    assign tx.status    = out_reg.status;

endmodule

// File: src/fastq_record_parser_trim_top.sv
// Top level of the FASTQ record parser with read trimming.
`include "fastq_record_parser_trim_top_defines.svh"

// FASTQ record parser. Takes one text byte per word on rx and works through
// four-line records (name, bases, separator, quality). Name bytes after '@'
// leave on tx as they arrive; bases go into a MAX_READ-deep base memory; each
// quality byte below the trimmed length leaves paired with its base; every
// record closes with one record-end word carrying a status. The trimmed
// length is min(floor(bases * keep_fraction_q16 / 65536), read_cutoff), fixed
// at the end of the base line; keep_fraction_q16 with bit 16 set skips scaling.
// Rate: one input word per cycle while the skid register is empty; results
// reach tx from the registered output stage. The parse state updates once
// per byte; the base memory is read ahead at the next quality position, so
// its registered read port sets no extra delay. Results pass a two-entry
// output stage (result register plus skid), so rx.ready is a register and
// drops only after tx has stalled with two results held. The memories need
// no clearing pass: only entries written in the current record are read, so
// the block is ready right after reset. Write configuration only while idle.
module fastq_record_parser_trim_top #(
    parameter int MAX_READ = fqp_pkg::MAX_READ_DEF,
    parameter int MAX_NAME = fqp_pkg::MAX_NAME_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fqp_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [fqp_pkg::CFG_DATA_W-1:0]  cfg_data,
    fqp_in_if.sink                          rx,
    fqp_out_if.source                       tx
);
    import fqp_pkg::*;

    localparam int IDX_W  = $clog2(MAX_READ);
    localparam int CNT_W  = $clog2(MAX_READ + 1);
    localparam int NLEN_W = $clog2(MAX_NAME + 1);
    localparam int PROD_W = CNT_W + KEEP_W - 1;
    localparam int CMP_W  = (CNT_W > CUTOFF_W) ? CNT_W : CUTOFF_W;

    // Configuration registers.
    logic [KEEP_W-1:0]   keep_reg;
    logic [CUTOFF_W-1:0] cutoff_reg;

    // Parse state.
    phase_t               phase_reg, phase_next;
    logic                 skip_reg, skip_next;
    logic                 started_reg, started_next;
    logic [NLEN_W-1:0]    name_len_reg, name_len_next;
    logic [CNT_W-1:0]     base_cnt_reg, base_cnt_next;
    logic [CNT_W-1:0]     trim_reg, trim_next;
    logic [SEP_LEN_W-1:0] sep_len_reg, sep_len_next;
    logic [CNT_W-1:0]     qual_cnt_reg, qual_cnt_next;
    logic [SEP_LEN_W-1:0] sep_len_cur;

    // Base memory with a registered read port.
    logic [7:0]       base_mem [MAX_READ];
    logic [7:0]       base_rd_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             base_we;

    // Line-end decision.
    phase_t  el_phase;
    logic    el_emit;
    status_t el_status;
    logic    el_base_clr;
    logic    el_trim_load;
    logic    el_sep_clr;
    logic    el_qual_clr;

    // Trim arithmetic.
    logic [PROD_W-1:0] product;
    logic [CNT_W-1:0]  scaled;
    logic [CNT_W-1:0]  trim_calc;

    logic       in_fire;
    logic       skid_ready;
    logic       res_valid;
    result_t    res;
    logic       name_push;
    logic       sep_push;
    logic       sep_match;
    match_ctl_t match_ctl;

    assign in_fire  = rx.valid && rx.ready;
    assign rx.ready = skid_ready;

    // Scale the base count by the Q0.16 fraction, then clamp to the cutoff.
    assign product   = PROD_W'(base_cnt_reg) * PROD_W'(keep_reg[KEEP_W-2:0]);
    assign scaled    = keep_reg[KEEP_W-1] ? base_cnt_reg : product[PROD_W-1:KEEP_W-1];
    assign trim_calc = (CMP_W'(scaled) > CMP_W'(cutoff_reg)) ? CNT_W'(cutoff_reg) : scaled;

    // What a newline (or a pending line at end of stream) does in each phase.
    always_comb
    begin
        el_phase     = phase_reg;
        el_emit      = 1'b0;
        el_status    = ST_OK;
        el_base_clr  = 1'b0;
        el_trim_load = 1'b0;
        el_sep_clr   = 1'b0;
        el_qual_clr  = 1'b0;
        unique case (phase_reg)
            PH_NAME:
            begin
                if (!started_reg)
                begin
                    el_emit   = 1'b1;
                    el_status = ST_BAD_NAME;
                end
                else
                begin
                    el_phase    = PH_SEQ;
                    el_base_clr = 1'b1;
                end
            end
            PH_SEQ:
            begin
                el_phase     = PH_SEP;
                el_trim_load = 1'b1;
                el_sep_clr   = 1'b1;
            end
            PH_SEP:
            begin
                if (!started_reg || !sep_match)
                begin
                    el_phase  = PH_NAME;
                    el_emit   = 1'b1;
                    el_status = ST_BAD_SEP;
                end
                else
                begin
                    el_phase    = PH_QUAL;
                    el_qual_clr = 1'b1;
                end
            end
            PH_QUAL:
            begin
                el_phase  = PH_NAME;
                el_emit   = 1'b1;
                el_status = (qual_cnt_reg == base_cnt_reg) ? ST_OK : ST_LEN_MISMATCH;
            end
            default:
            begin
                el_phase = PH_NAME;
            end
        endcase
    end

    // Next state and result for the word on rx.
    always_comb
    begin
        phase_next    = phase_reg;
        skip_next     = skip_reg;
        started_next  = started_reg;
        name_len_next = name_len_reg;
        base_cnt_next = base_cnt_reg;
        trim_next     = trim_reg;
        sep_len_next  = sep_len_reg;
        qual_cnt_next = qual_cnt_reg;
        sep_len_cur   = started_reg ? sep_len_reg : '0;
        res_valid     = 1'b0;
        res           = '{kind: KIND_NAME, data_byte: '0, qual_byte: '0, status: ST_OK};
        name_push     = 1'b0;
        sep_push      = 1'b0;
        base_we       = 1'b0;

        priority if (rx.stream_end)
        begin
            // Close a pending line, report, then drop all parse state.
            if (!skip_reg)
            begin
                if (started_reg && el_emit)
                begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_END;
                    res.status = el_status;
                end
                else if ((started_reg ? el_phase : phase_reg) != PH_NAME)
                begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_END;
                    res.status = ST_TRUNCATED;
                end
            end
            phase_next    = PH_NAME;
            skip_next     = 1'b0;
            started_next  = 1'b0;
            name_len_next = '0;
            base_cnt_next = '0;
            trim_next     = '0;
            sep_len_next  = '0;
            qual_cnt_next = '0;
        end
        else if (skip_reg)
        begin
            // Drop the rest of a failed line.
            if (rx.ch == CH_NEWLINE)
            begin
                skip_next = 1'b0;
            end
        end
        else if (rx.ch == CH_NEWLINE)
        begin
            phase_next   = el_phase;
            started_next = 1'b0;
            if (el_emit)
            begin
                res_valid  = 1'b1;
                res.kind   = KIND_END;
                res.status = el_status;
            end
            if (el_base_clr)
            begin
                base_cnt_next = '0;
            end
            if (el_trim_load)
            begin
                trim_next = trim_calc;
            end
            if (el_sep_clr)
            begin
                sep_len_next = '0;
            end
            if (el_qual_clr)
            begin
                qual_cnt_next = '0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_NAME:
                begin
                    if (!started_reg)
                    begin
                        started_next  = 1'b1;
                        name_len_next = '0;
                        if (rx.ch != CH_AT)
                        begin
                            phase_next   = PH_NAME;
                            skip_next    = 1'b1;
                            started_next = 1'b0;
                            res_valid    = 1'b1;
                            res.kind     = KIND_END;
                            res.status   = ST_BAD_NAME;
                        end
                    end
                    else if (name_len_reg >= NLEN_W'(MAX_NAME))
                    begin
                        phase_next   = PH_NAME;
                        skip_next    = 1'b1;
                        started_next = 1'b0;
                        res_valid    = 1'b1;
                        res.kind     = KIND_END;
                        res.status   = ST_OVERFLOW;
                    end
                    else
                    begin
                        name_push     = 1'b1;
                        name_len_next = name_len_reg + 1'b1;
                        res_valid     = 1'b1;
                        res.kind      = KIND_NAME;
                        res.data_byte = rx.ch;
                    end
                end
                PH_SEQ:
                begin
                    if (base_cnt_reg >= CNT_W'(MAX_READ))
                    begin
                        phase_next   = PH_NAME;
                        skip_next    = 1'b1;
                        started_next = 1'b0;
                        res_valid    = 1'b1;
                        res.kind     = KIND_END;
                        res.status   = ST_OVERFLOW;
                    end
                    else
                    begin
                        started_next  = 1'b1;
                        base_we       = 1'b1;
                        base_cnt_next = base_cnt_reg + 1'b1;
                    end
                end
                PH_SEP:
                begin
                    if (!started_reg && (rx.ch != CH_PLUS))
                    begin
                        sep_len_next = '0;
                        phase_next   = PH_NAME;
                        skip_next    = 1'b1;
                        started_next = 1'b0;
                        res_valid    = 1'b1;
                        res.kind     = KIND_END;
                        res.status   = ST_BAD_SEP;
                    end
                    else
                    begin
                        started_next = 1'b1;
                        sep_push     = 1'b1;
                        sep_len_next = (sep_len_cur == SEP_LEN_MAX) ? sep_len_cur
                                                                    : sep_len_cur + 1'b1;
                    end
                end
                PH_QUAL:
                begin
                    if (qual_cnt_reg >= base_cnt_reg)
                    begin
                        phase_next   = PH_NAME;
                        skip_next    = 1'b1;
                        started_next = 1'b0;
                        res_valid    = 1'b1;
                        res.kind     = KIND_END;
                        res.status   = ST_LEN_MISMATCH;
                    end
                    else
                    begin
                        started_next = 1'b1;
                        if (qual_cnt_reg < trim_reg)
                        begin
                            res_valid     = 1'b1;
                            res.kind      = KIND_PAIR;
                            res.data_byte = base_rd_reg;
                            res.qual_byte = rx.ch;
                        end
                        qual_cnt_next = qual_cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_NAME;
                end
            endcase
        end
    end

    // State, cfg regs; users make configuration writes only while idle, unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg     <= KEEP_RESET;
            cutoff_reg   <= CUTOFF_RESET;
            phase_reg    <= PH_NAME;
            skip_reg     <= 1'b0;
            started_reg  <= 1'b0;
            name_len_reg <= '0;
            base_cnt_reg <= '0;
            trim_reg     <= '0;
            sep_len_reg  <= '0;
            qual_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_KEEP_FRACTION: keep_reg   <= cfg_data[KEEP_W-1:0];
                    CFG_READ_CUTOFF:   cutoff_reg <= cfg_data[CUTOFF_W-1:0];
                    default:           keep_reg   <= keep_reg;
                endcase
            end
            if (in_fire)
            begin
                phase_reg    <= phase_next;
                skip_reg     <= skip_next;
                started_reg  <= started_next;
                name_len_reg <= name_len_next;
                base_cnt_reg <= base_cnt_next;
                trim_reg     <= trim_next;
                sep_len_reg  <= sep_len_next;
                qual_cnt_reg <= qual_cnt_next;
            end
        end
    end

    // Read one step ahead so the base for the next quality byte is ready.
    assign rd_addr = in_fire ? qual_cnt_next[IDX_W-1:0] : qual_cnt_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (in_fire && base_we)
        begin
            base_mem[base_cnt_reg[IDX_W-1:0]] <= rx.ch;
        end
        base_rd_reg <= base_mem[rd_addr];
    end

    assign match_ctl = '{name_push: in_fire && name_push,
                         sep_push:  in_fire && sep_push,
                         data:      rx.ch};

    fqp_sep_match #(
        .MAX_NAME (MAX_NAME),
        .NLEN_W   (NLEN_W)
    ) u_sep_match (
        .clk      (clk),
        .ctl      (match_ctl),
        .name_len (name_len_reg),
        .sep_len  (sep_len_reg),
        .match    (sep_match)
    );

    fqp_out_skid u_out_skid (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (in_fire && res_valid),
        .item  (res),
        .ready (skid_ready),
        .tx    (tx)
    );

    `FQP_IMPLY(a_skip_in_name, skip_reg, (phase_reg == PH_NAME) && !started_reg, "skip outside name phase")
    `FQP_IMPLY(a_qual_bounds, phase_reg == PH_QUAL, (qual_cnt_reg <= base_cnt_reg) && (trim_reg <= base_cnt_reg), "quality count or trim past base count")
    `FQP_IMPLY(a_pair_in_qual, in_fire && res_valid && (res.kind == KIND_PAIR), (phase_reg == PH_QUAL) && (qual_cnt_reg < trim_reg), "pair outside trimmed quality")
    `FQP_NEXT(a_end_to_name, in_fire && res_valid && (res.kind == KIND_END), (phase_reg == PH_NAME) && !started_reg, "record end did not return to name phase")

endmodule

// File: test/fastq_record_parser_trim_top_test.sv
// Self-checking testbench for the FASTQ record parser with read trimming.
module fastq_record_parser_trim_top_test;
    import fqp_pkg::*;

    localparam int NAME_DEPTH    = MAX_NAME_DEF;
    localparam int READ_DEPTH    = MAX_READ_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 20;

    // Shapes of the separator line that the record builder can produce.
    typedef enum int {
        SEP_ANY,
        SEP_BARE,
        SEP_NAME,
        SEP_PREFIX_NAME,
        SEP_JUNK,
        SEP_EMPTY,
        SEP_NO_PLUS,
        SEP_NEAR_NAME
    } sep_form_t;

    // Length of the quality line against the base line.
    typedef enum int {
        QUAL_ANY,
        QUAL_EXACT,
        QUAL_SHORT,
        QUAL_LONG
    } qual_form_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } text_word_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    fqp_in_if  rx_if ();
    fqp_out_if tx_if ();

    fastq_record_parser_trim_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .rx       (rx_if),
        .tx       (tx_if)
    );

    // ------------------------------------------------------------------
    // Parser state as seen by the predictor
    // ------------------------------------------------------------------
    logic [KEEP_W-1:0]    keep_frac;
    logic [CUTOFF_W-1:0]  max_bases;

    phase_t               ln_phase;
    bit                   skipping;
    bit                   in_line;
    logic [7:0]           name_buf [NAME_DEPTH];
    logic [6:0]           name_cnt;
    logic [7:0]           read_buf [READ_DEPTH];
    logic [10:0]          read_cnt;
    logic [10:0]          keep_cnt;
    logic [7:0]           plus_tail [NAME_DEPTH+1];
    logic [SEP_LEN_W-1:0] plus_cnt;
    logic [10:0]          qual_pos;

    // Output words the parser owes, oldest first.
    result_t    parsed_words_q [$];
    result_t    oldest_word;

    // Stimulus: text words waiting for the driver, and the record being built.
    text_word_t feed_q [$];
    text_word_t rec_buf [$];
    text_word_t held_word = '0;
    int         queued_words = 0;

    // Handshake bookkeeping.
    bit         offering   = 1'b0;
    bit         word_taken = 1'b0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         rx_hold_req  = 1'b0;
    bit         rx_hold_seen = 1'b0;
    int         rx_hold_left = 0;

    int         accepted_words = 0;
    int         checked_words  = 0;
    int         record_ends    = 0;
    int         mismatch_count = 0;
    int         settings_used  = 1;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void reset_parse();
        ln_phase = PH_NAME;
        skipping = 1'b0;
        in_line  = 1'b0;
        name_cnt = '0;
        read_cnt = '0;
        keep_cnt = '0;
        plus_cnt = '0;
        qual_pos = '0;
    endfunction

    function automatic void push_word(kind_t k, logic [7:0] d, logic [7:0] q, status_t s);
        result_t w;
        w.kind      = k;
        w.data_byte = d;
        w.qual_byte = q;
        w.status    = s;
        parsed_words_q.push_back(w);
    endfunction

    // Close the record with an error; midline means drop the rest of the line.
    function automatic void abort_record(status_t s, bit midline);
        ln_phase = PH_NAME;
        skipping = midline;
        in_line  = 1'b0;
        push_word(KIND_END, 8'd0, 8'd0, s);
    endfunction

    // A separator is good if it is a lone '+' or its tail repeats the name.
    function automatic bit tail_holds_name();
        if (plus_cnt == 1)
            return 1'b1;
        if (plus_cnt < name_cnt)
            return 1'b0;
        for (int k = 0; k < name_cnt; k++)
        begin
            if (plus_tail[k] != name_buf[name_cnt - 1 - k])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Handle a newline; returns 1 when it produced a word.
    function automatic bit finish_line();
        logic [27:0] scaled;
        case (ln_phase)
            PH_NAME:
            begin
                if (!in_line)
                begin
                    abort_record(ST_BAD_NAME, 1'b0);
                    return 1'b1;
                end
                ln_phase = PH_SEQ;
                read_cnt = '0;
                in_line  = 1'b0;
                return 1'b0;
            end
            PH_SEQ:
            begin
                scaled = 28'(read_cnt);
                if (keep_frac < KEEP_RESET)
                    scaled = (28'(read_cnt) * 28'(keep_frac)) >> 16;
                if (scaled > 28'(max_bases))
                    scaled = 28'(max_bases);
                keep_cnt = scaled[10:0];
                ln_phase = PH_SEP;
                plus_cnt = '0;
                in_line  = 1'b0;
                return 1'b0;
            end
            PH_SEP:
            begin
                if (!in_line || !tail_holds_name())
                begin
                    abort_record(ST_BAD_SEP, 1'b0);
                    return 1'b1;
                end
                ln_phase = PH_QUAL;
                qual_pos = '0;
                in_line  = 1'b0;
                return 1'b0;
            end
            default:
            begin
                ln_phase = PH_NAME;
                in_line  = 1'b0;
                push_word(KIND_END, 8'd0, 8'd0,
                          (qual_pos == read_cnt) ? ST_OK : ST_LEN_MISMATCH);
                return 1'b1;
            end
        endcase
    endfunction

    // Advance the predictor by one accepted text word.
    function automatic void parse_text_byte(logic [7:0] c, logic eos);
        bit produced;
        produced = 1'b0;
        if (eos)
        begin
            if (!skipping)
            begin
                if (in_line)
                    produced = finish_line();
                if (!produced && ln_phase != PH_NAME)
                    push_word(KIND_END, 8'd0, 8'd0, ST_TRUNCATED);
            end
            reset_parse();
            return;
        end
        if (skipping)
        begin
            if (c == CH_NEWLINE)
                skipping = 1'b0;
            return;
        end
        if (c == CH_NEWLINE)
        begin
            void'(finish_line());
            return;
        end
        case (ln_phase)
            PH_NAME:
            begin
                if (!in_line)
                begin
                    in_line  = 1'b1;
                    name_cnt = '0;
                    if (c != CH_AT)
                        abort_record(ST_BAD_NAME, 1'b1);
                end
                else if (name_cnt >= NAME_DEPTH)
                    abort_record(ST_OVERFLOW, 1'b1);
                else
                begin
                    name_buf[name_cnt] = c;
                    name_cnt++;
                    push_word(KIND_NAME, c, 8'd0, ST_OK);
                end
            end
            PH_SEQ:
            begin
                in_line = 1'b1;
                if (read_cnt >= READ_DEPTH)
                    abort_record(ST_OVERFLOW, 1'b1);
                else
                begin
                    read_buf[read_cnt] = c;
                    read_cnt++;
                end
            end
            PH_SEP:
            begin
                if (!in_line)
                begin
                    in_line  = 1'b1;
                    plus_cnt = '0;
                    if (c != CH_PLUS)
                    begin
                        abort_record(ST_BAD_SEP, 1'b1);
                        return;
                    end
                end
                for (int i = NAME_DEPTH; i > 0; i--)
                    plus_tail[i] = plus_tail[i-1];
                plus_tail[0] = c;
                if (plus_cnt < SEP_LEN_MAX)
                    plus_cnt++;
            end
            default:
            begin
                in_line = 1'b1;
                if (qual_pos >= read_cnt)
                    abort_record(ST_LEN_MISMATCH, 1'b1);
                else
                begin
                    if (qual_pos < keep_cnt)
                        push_word(KIND_PAIR, read_buf[qual_pos], c, ST_OK);
                    qual_pos++;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    // Any byte but newline; newlines are placed on purpose.
    function automatic logic [7:0] any_text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_NEWLINE)
            b = 8'($urandom_range(11, 255));
        return b;
    endfunction

    function automatic void put_byte(logic [7:0] c);
        text_word_t w;
        w.ch  = c;
        w.eos = 1'b0;
        rec_buf.push_back(w);
    endfunction

    // The byte that travels with end of stream is ignored; randomize it.
    function automatic void put_eos();
        text_word_t w;
        w.ch  = 8'($urandom_range(0, 255));
        w.eos = 1'b1;
        rec_buf.push_back(w);
    endfunction

    function automatic void put_junk(int n);
        for (int i = 0; i < n; i++)
            put_byte(any_text_byte());
    endfunction

    function automatic void queue_record();
        foreach (rec_buf[i])
            feed_q.push_back(rec_buf[i]);
        queued_words += rec_buf.size();
        rec_buf.delete();
    endfunction

    // Build one four-line record; rough allows a bad name line and an
    // end of stream cut into or after the record.
    function automatic void add_record(int nlen, int blen, sep_form_t sf, qual_form_t qf,
                                       bit rough);
        logic [7:0] nm [$];
        logic [7:0] b;
        int         roll;
        int         qlen;
        int         k;
        rec_buf.delete();
        for (int i = 0; i < nlen; i++)
            nm.push_back(any_text_byte());

        roll = rough ? $urandom_range(0, 99) : 99;
        if (roll < 3)
            put_byte(CH_NEWLINE);
        else
        begin
            b = any_text_byte();
            if (b == CH_AT)
                b = b + 1;
            put_byte(roll < 6 ? b : CH_AT);
            foreach (nm[i])
                put_byte(nm[i]);
            put_byte(CH_NEWLINE);
        end

        put_junk(blen);
        put_byte(CH_NEWLINE);

        if (sf == SEP_ANY)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)      sf = SEP_BARE;
            else if (roll < 65) sf = SEP_NAME;
            else if (roll < 75) sf = SEP_PREFIX_NAME;
            else if (roll < 83) sf = SEP_JUNK;
            else if (roll < 87) sf = SEP_EMPTY;
            else if (roll < 91) sf = SEP_NO_PLUS;
            else                sf = SEP_NEAR_NAME;
        end
        case (sf)
            SEP_BARE:
                put_byte(CH_PLUS);
            SEP_NAME:
            begin
                put_byte(CH_PLUS);
                foreach (nm[i])
                    put_byte(nm[i]);
            end
            SEP_PREFIX_NAME:
            begin
                put_byte(CH_PLUS);
                put_junk($urandom_range(1, 8));
                foreach (nm[i])
                    put_byte(nm[i]);
            end
            SEP_JUNK:
            begin
                put_byte(CH_PLUS);
                put_junk($urandom_range(1, 8));
            end
            SEP_NO_PLUS:
            begin
                b = any_text_byte();
                if (b == CH_PLUS)
                    b = b + 1;
                put_byte(b);
                put_junk($urandom_range(0, 4));
            end
            SEP_NEAR_NAME:
            begin
                put_byte(CH_PLUS);
                if (nm.size() == 0)
                    put_junk(1);
                else
                begin
                    // Change one name byte so that only the tail check catches it.
                    k = $urandom_range(0, nm.size() - 1);
                    foreach (nm[i])
                    begin
                        b = nm[i];
                        if (i == k)
                        begin
                            b = b + 1;
                            if (b == CH_NEWLINE)
                                b = b + 1;
                        end
                        put_byte(b);
                    end
                end
            end
            default:
                ;
        endcase
        put_byte(CH_NEWLINE);

        if (qf == QUAL_ANY)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 86)      qf = QUAL_EXACT;
            else if (roll < 93) qf = QUAL_SHORT;
            else                qf = QUAL_LONG;
        end
        qlen = blen;
        if (qf == QUAL_SHORT)
            qlen = (blen == 0) ? 0 : $urandom_range(0, blen - 1);
        else if (qf == QUAL_LONG)
            qlen = blen + $urandom_range(1, 3);
        put_junk(qlen);
        put_byte(CH_NEWLINE);

        if (rough)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                // Cut the record anywhere and end the stream there.
                k = $urandom_range(0, rec_buf.size() - 1);
                while (rec_buf.size() > k)
                    void'(rec_buf.pop_back());
                put_eos();
            end
            else if (roll < 9)
                put_eos();
        end
        queue_record();
    endfunction

    // Short burst of garbage, heavy on newlines and the two marker bytes.
    function automatic void add_noise();
        int roll;
        rec_buf.delete();
        for (int i = $urandom_range(1, 12); i > 0; i--)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15)      put_byte(CH_NEWLINE);
            else if (roll < 25) put_byte(CH_AT);
            else if (roll < 35) put_byte(CH_PLUS);
            else                put_byte(any_text_byte());
        end
        if ($urandom_range(0, 1) == 0)
            put_eos();
        else
            put_byte(CH_NEWLINE);
        queue_record();
    endfunction

    // Mostly well-formed records with random content, some noise and stream ends.
    function automatic void add_random_items(int count);
        int goal;
        int roll;
        int nlen;
        int blen;
        goal = queued_words + count;
        while (queued_words < goal)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 90)
            begin
                nlen = ($urandom_range(0, 99) < 3) ? $urandom_range(60, 66)
                                                  : $urandom_range(0, 10);
                blen = ($urandom_range(0, 99) < 5) ? $urandom_range(25, 80)
                                                  : $urandom_range(0, 24);
                add_record(nlen, blen, SEP_ANY, QUAL_ANY, 1'b1);
            end
            else if (roll < 95)
                add_noise();
            else
            begin
                rec_buf.delete();
                put_eos();
                queue_record();
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------
    // Hold the sender until every owed word is out, then let the block settle.
    task automatic wait_drained();
        while (feed_q.size() != 0 || offering || parsed_words_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_KEEP_FRACTION)
            keep_frac = val[KEEP_W-1:0];
        else
            max_bases = val[CUTOFF_W-1:0];
    endtask

    task automatic set_config(logic [KEEP_W-1:0] keep, logic [CUTOFF_W-1:0] cut);
        write_reg(CFG_KEEP_FRACTION, CFG_DATA_W'(keep));
        write_reg(CFG_READ_CUTOFF, CFG_DATA_W'(cut));
        settings_used++;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: offer one text word at a time, change inputs on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            rx_if.valid <= 1'b0;
        else
        begin
            // Drop the word that went in at the last rising edge.
            if (word_taken)
            begin
                offering   = 1'b0;
                word_taken = 1'b0;
            end
            // Idle only between words; once offered, hold the word until taken.
            if (!offering && feed_q.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct)
            begin
                held_word = feed_q.pop_front();
                offering  = 1'b1;
            end
            rx_if.valid      <= offering;
            rx_if.ch         <= held_word.ch;
            rx_if.stream_end <= held_word.eos;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure plus a long hold on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_hold_req != rx_hold_seen)
        begin
            rx_hold_seen = rx_hold_req;
            rx_hold_left = LONG_HOLD;
        end
        if (rx_hold_left != 0)
        begin
            rx_hold_left--;
            tx_if.ready <= 1'b0;
        end
        else
            tx_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted input, check every accepted output
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Predict first so a result can never outrun its expectation.
            if (rx_if.valid && rx_if.ready)
            begin
                parse_text_byte(rx_if.ch, rx_if.stream_end);
                accepted_words++;
                word_taken = 1'b1;
            end
            if (tx_if.valid && tx_if.ready)
            begin
                checked_words++;
                if (parsed_words_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected word kind=%0d data=%02h qual=%02h status=%0d",
                                 $time, tx_if.kind, tx_if.data_byte, tx_if.qual_byte,
                                 tx_if.status);
                end
                else
                begin
                    oldest_word = parsed_words_q.pop_front();
                    if (oldest_word.kind == KIND_END)
                        record_ends++;
                    if (tx_if.kind !== oldest_word.kind ||
                        tx_if.data_byte !== oldest_word.data_byte ||
                        tx_if.qual_byte !== oldest_word.qual_byte ||
                        tx_if.status !== oldest_word.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: mismatch, expected kind=%0d data=%02h qual=%02h ",
                                     $time, oldest_word.kind, oldest_word.data_byte,
                                     oldest_word.qual_byte,
                                     "status=%0d, got kind=%0d data=%02h qual=%02h status=%0d",
                                     oldest_word.status, tx_if.kind, tx_if.data_byte,
                                     tx_if.qual_byte, tx_if.status);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout: %0d words still owed, %0d text words unsent",
                 parsed_words_q.size(), feed_q.size());
        $display("** fastq_record_parser_trim_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Drive every input to a known value before the first edge.
        rx_if.valid      = 1'b0;
        rx_if.ch         = 8'd0;
        rx_if.stream_end = 1'b0;
        tx_if.ready      = 1'b0;
        keep_frac        = KEEP_RESET;
        max_bases        = CUTOFF_RESET;
        reset_parse();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 62;

        // Directed words at reset settings: empty name line, stray first byte,
        // a clean record with extreme bytes and a carriage return in the name,
        // a separator without '+', a lone stream end, and a truncated record.
        rec_buf.delete();
        put_byte(CH_NEWLINE);
        put_byte("x");
        put_byte(CH_NEWLINE);
        put_byte(CH_AT);
        put_byte(8'hFF);
        put_byte(8'h0D);
        put_byte(CH_NEWLINE);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(CH_NEWLINE);
        put_byte(CH_PLUS);
        put_byte(CH_NEWLINE);
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(CH_NEWLINE);
        put_byte(CH_AT);
        put_byte("a");
        put_byte(CH_NEWLINE);
        put_byte("C");
        put_byte(CH_NEWLINE);
        put_byte("-");
        put_byte(CH_NEWLINE);
        put_eos();
        put_byte(CH_AT);
        put_byte(CH_NEWLINE);
        put_byte("G");
        put_eos();
        queue_record();
        wait_drained();

        // Full read kept: longest name, name overflow, short and long quality lines.
        set_config(KEEP_RESET, CUTOFF_RESET);
        add_record(NAME_DEPTH, 3, SEP_NAME, QUAL_EXACT, 1'b0);
        add_record(NAME_DEPTH + 1, 2, SEP_BARE, QUAL_EXACT, 1'b0);
        add_record(3, 5, SEP_NAME, QUAL_SHORT, 1'b0);
        add_record(3, 5, SEP_BARE, QUAL_LONG, 1'b0);
        // Pause the sender here until every owed word has come out.
        wait_drained();
        add_random_items(50);
        wait_drained();

        // Zero fraction: no pairs at all, only framing.
        set_config('0, CUTOFF_RESET);
        add_random_items(30);
        wait_drained();

        // Swap the idle profiles; random fraction, small cutoff.
        send_idle_pct = 62;
        recv_idle_pct = 36;
        set_config(KEEP_W'($urandom_range(1, 65535)), CUTOFF_W'($urandom_range(0, 40)));
        add_random_items(50);
        wait_drained();

        // Largest scaling fraction with a zero cutoff.
        set_config(KEEP_W'(65535), '0);
        add_random_items(30);
        wait_drained();

        // No idling; stall the receiver long enough to back the input up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(KEEP_W'(32768), CUTOFF_RESET);
        add_random_items(50);
        rx_hold_req = ~rx_hold_req;
        wait_drained();

        set_config(KEEP_W'($urandom_range(0, 65536)), CUTOFF_W'($urandom_range(0, 1024)));
        add_random_items(50);
        wait_drained();

        $display("Run covered %0d text words and %0d output words, %0d of them record ends,",
                 accepted_words, checked_words, record_ends);
        $display("over %0d register settings, three idle profiles and a long output stall.",
                 settings_used);
        if (mismatch_count == 0 && parsed_words_q.size() == 0)
            $display("** fastq_record_parser_trim_top: PASSED **");
        else
            $display("** fastq_record_parser_trim_top: FAILED **");
        $finish;
    end

endmodule
